// ----- rtl/mwm_pkg.sv -----
`default_nettype none

package mwm_pkg;

   localparam int LANES      = 4;
   localparam int WHEEL_W    = 16;
   localparam int MAG_W      = 16;
   localparam int QUO_W      = 15;
   localparam int REM_W      = 30;
   localparam int DIV_STAGES = QUO_W;

   localparam logic signed [WHEEL_W-1:0] BOOST_Y_MIN  = 16'sd5000;
   localparam logic signed [WHEEL_W-1:0] BOOST_R_MAX  = 16'sd50;
   localparam logic signed [WHEEL_W-1:0] BOOST_R_MIN  = 16'sd5;
   localparam logic signed [WHEEL_W-1:0] BOOST_FACTOR = 16'sd10;

   typedef enum logic [1:0] {
      CSR_TRANSLATE_GAIN = 2'd0,
      CSR_ROTATE_GAIN    = 2'd1,
      CSR_SPEED_LIMIT    = 2'd2
   } csr_index_type;

   // One item inside the divider: per-lane remainder and quotient so far,
   // plus what the output stage needs to pick and sign the result.
   typedef struct packed {
      logic [LANES-1:0][REM_W-1:0]   rem;
      logic [LANES-1:0][QUO_W-1:0]   quo;
      logic [MAG_W-1:0]              max_mag;
      logic [LANES-1:0]              neg;
      logic [LANES-1:0][WHEEL_W-1:0] wheel;
      logic                          scaled;
   } mwm_div_type;

   function automatic logic signed [WHEEL_W-1:0] sat16(input logic signed [21:0] v);
      logic signed [WHEEL_W-1:0] res;
      if (v > 22'sd32767) begin
         res = 16'sh7FFF;
      end else if (v < -22'sd32768) begin
         res = 16'sh8000;
      end else begin
         res = v[WHEEL_W-1:0];
      end
      return res;
   endfunction

   // Magnitude as unsigned; the most negative value gives 32768.
   function automatic logic [MAG_W-1:0] mag16(input logic [WHEEL_W-1:0] v);
      logic [MAG_W-1:0] res;
      if (v[WHEEL_W-1]) begin
         res = ~v + 16'd1;
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/mwm_div.sv -----
`default_nettype none

module mwm_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire mwm_pkg::mwm_div_type in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output mwm_pkg::mwm_div_type     out_data
);
   import mwm_pkg::*;

   mwm_div_type            pipe [DIV_STAGES+1];
   mwm_div_type            stage_ff [DIV_STAGES];
   mwm_div_type            stage_in [DIV_STAGES];
   logic [DIV_STAGES:0]    vpipe;
   logic [DIV_STAGES:0]    rdy;
   logic [DIV_STAGES-1:0]  valid_ff;

   assign pipe[0]         = in_data;
   assign vpipe[0]        = in_valid;
   assign rdy[DIV_STAGES] = out_ready;

   // Restoring division, one quotient bit per stage, MSB first.
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      localparam int SHIFT = DIV_STAGES - 1 - k;

      assign pipe[k+1]  = stage_ff[k];
      assign vpipe[k+1] = valid_ff[k];
      assign rdy[k]     = !valid_ff[k] || rdy[k+1];

      always_comb begin
         logic [REM_W-1:0] dsh;
         logic             ge;
         dsh         = REM_W'(pipe[k].max_mag) << SHIFT;
         stage_in[k] = pipe[k];
         for (int i = 0; i < LANES; i++) begin
            ge = (pipe[k].rem[i] >= dsh);
            if (ge) begin
               stage_in[k].rem[i] = pipe[k].rem[i] - dsh;
            end
            stage_in[k].quo[i] = {pipe[k].quo[i][QUO_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            valid_ff[k] <= vpipe[k];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && vpipe[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vpipe[DIV_STAGES];
   assign out_data  = pipe[DIV_STAGES];

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[DIV_STAGES-1] && !out_ready) |=>
         (valid_ff[DIV_STAGES-1] && $stable(stage_ff[DIV_STAGES-1])))
      else $error("divider output item changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> valid_ff[0])
      else $error("accepted item missing from first divider stage");

   assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> ((&valid_ff) && !out_ready))
      else $error("divider stalled with a bubble inside");

endmodule

`default_nettype wire

// ----- rtl/mecanum_wheel_mix_normalize_core.sv -----
`default_nettype none

// Mecanum wheel mixer with proportional speed limiting. Takes one chassis
// command per cycle unless stalled and returns four saturated wheel speeds;
// when the largest wheel magnitude m exceeds speed_limit, every wheel w becomes
// trunc(w * speed_limit / m) and rsp_scaled is set. From acceptance to
// rsp_valid an item passes four front stages (gains, boost and mix, magnitudes,
// max and limit products), 15 stages of a bit-per-stage restoring divider per
// wheel (the quotient width sets this part), and the output register. Stalls
// on rsp_ready only back up into stages that hold items, so empty stages still
// take new input. The user must write registers through the csr_ port only
// while it is idle; the block does not enforce this. Index 3 is ignored.

module mecanum_wheel_mix_normalize_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [14:0]        csr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_func,
   input  wire logic signed [15:0] req_cmd_x,
   input  wire logic signed [15:0] req_cmd_y,
   input  wire logic signed [15:0] req_cmd_rotation,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [15:0]      rsp_wheel_a,
   output logic signed [15:0]      rsp_wheel_b,
   output logic signed [15:0]      rsp_wheel_c,
   output logic signed [15:0]      rsp_wheel_d,
   output logic                    rsp_scaled
);
   import mwm_pkg::*;

   logic [4:0]  translate_gain_ff;
   logic [4:0]  rotate_gain_ff;
   logic [14:0] speed_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         translate_gain_ff <= 5'd1;
         rotate_gain_ff    <= 5'd1;
         speed_limit_ff    <= 15'd600;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TRANSLATE_GAIN: translate_gain_ff <= csr_data[4:0];
            CSR_ROTATE_GAIN:    rotate_gain_ff    <= csr_data[4:0];
            CSR_SPEED_LIMIT:    speed_limit_ff    <= csr_data;
            default:            ;
         endcase
      end
   end

   // Ready chain: a stage moves when it is empty or its successor moves.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, out_rdy;
   logic div_in_ready, div_out_valid;
   mwm_div_type div_in_ff, div_in_in, div_out;

   assign out_rdy   = !rsp_valid || rsp_ready;
   assign s4_rdy    = !s4_valid_ff || div_in_ready;
   assign s3_rdy    = !s3_valid_ff || s4_rdy;
   assign s2_rdy    = !s2_valid_ff || s3_rdy;
   assign s1_rdy    = !s1_valid_ff || s2_rdy;
   assign req_ready = s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_valid_ff <= req_valid;
         if (s2_rdy) s2_valid_ff <= s1_valid_ff;
         if (s3_rdy) s3_valid_ff <= s2_valid_ff;
         if (s4_rdy) s4_valid_ff <= s3_valid_ff;
      end
   end

   // Stage 1: gain products, saturated; keyboard commands keep x and y ungained.
   logic signed [21:0]        x_prod, y_prod, r_prod;
   logic signed [WHEEL_W-1:0] s1_x_ff, s1_y_ff, s1_r_ff;
   logic signed [WHEEL_W-1:0] s1_x_in, s1_y_in, s1_r_in;
   logic                      s1_keyboard_ff, s1_y_big_ff, s1_y_big_in;

   assign x_prod = 22'(req_cmd_x) * 22'($signed({1'b0, translate_gain_ff}));
   assign y_prod = 22'(req_cmd_y) * 22'($signed({1'b0, translate_gain_ff}));
   assign r_prod = 22'(req_cmd_rotation) * 22'($signed({1'b0, rotate_gain_ff}));

   assign s1_x_in     = req_func ? req_cmd_x : sat16(x_prod);
   assign s1_y_in     = req_func ? req_cmd_y : sat16(y_prod);
   assign s1_r_in     = sat16(r_prod);
   assign s1_y_big_in = (req_cmd_y > BOOST_Y_MIN) || (req_cmd_y < -BOOST_Y_MIN);

   always_ff @(posedge clock) begin
      if (s1_rdy && req_valid) begin
         s1_x_ff        <= s1_x_in;
         s1_y_ff        <= s1_y_in;
         s1_r_ff        <= s1_r_in;
         s1_keyboard_ff <= req_func;
         s1_y_big_ff    <= s1_y_big_in;
      end
   end

   // Stage 2: keyboard rotation boost and wheel mixing.
   logic                         boost;
   logic signed [WHEEL_W-1:0]    r_eff;
   logic signed [17:0]           sum_a, sum_b, sum_c, sum_d;
   logic [LANES-1:0][WHEEL_W-1:0] s2_wheel_ff, s2_wheel_in;

   // Rotation window: 5 < |r| < 50, so r * 10 fits easily.
   assign boost = s1_keyboard_ff && s1_y_big_ff &&
                  (((s1_r_ff > BOOST_R_MIN) && (s1_r_ff < BOOST_R_MAX)) ||
                   ((s1_r_ff < -BOOST_R_MIN) && (s1_r_ff > -BOOST_R_MAX)));
   assign r_eff = boost ? WHEEL_W'(s1_r_ff * BOOST_FACTOR) : s1_r_ff;

   assign sum_a =  18'(s1_x_ff) + 18'(s1_y_ff) + 18'(r_eff);
   assign sum_b =  18'(s1_x_ff) - 18'(s1_y_ff) + 18'(r_eff);
   assign sum_c = -18'(s1_x_ff) - 18'(s1_y_ff) + 18'(r_eff);
   assign sum_d = -18'(s1_x_ff) + 18'(s1_y_ff) + 18'(r_eff);

   assign s2_wheel_in[0] = sat16(22'(sum_a));
   assign s2_wheel_in[1] = sat16(22'(sum_b));
   assign s2_wheel_in[2] = sat16(22'(sum_c));
   assign s2_wheel_in[3] = sat16(22'(sum_d));

   always_ff @(posedge clock) begin
      if (s2_rdy && s1_valid_ff) begin
         s2_wheel_ff <= s2_wheel_in;
      end
   end

   // Stage 3: magnitudes and first level of the max tree.
   logic [LANES-1:0][MAG_W-1:0]   mag_in, s3_mag_ff;
   logic [LANES-1:0][WHEEL_W-1:0] s3_wheel_ff;
   logic [MAG_W-1:0]              s3_max_ab_ff, s3_max_cd_ff;
   logic [MAG_W-1:0]              s3_max_ab_in, s3_max_cd_in;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         mag_in[i] = mag16(s2_wheel_ff[i]);
      end
   end

   assign s3_max_ab_in = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
   assign s3_max_cd_in = (mag_in[2] > mag_in[3]) ? mag_in[2] : mag_in[3];

   always_ff @(posedge clock) begin
      if (s3_rdy && s2_valid_ff) begin
         s3_mag_ff    <= mag_in;
         s3_wheel_ff  <= s2_wheel_ff;
         s3_max_ab_ff <= s3_max_ab_in;
         s3_max_cd_ff <= s3_max_cd_in;
      end
   end

   // Stage 4: overall max, limit compare, dividends |w| * limit (< 2^30).
   logic [MAG_W-1:0] max_mag;
   logic [30:0]      limit_prod [LANES];

   assign max_mag = (s3_max_ab_ff > s3_max_cd_ff) ? s3_max_ab_ff : s3_max_cd_ff;

   always_comb begin
      div_in_in.max_mag = max_mag;
      div_in_in.scaled  = (max_mag > {1'b0, speed_limit_ff});
      div_in_in.wheel   = s3_wheel_ff;
      for (int i = 0; i < LANES; i++) begin
         limit_prod[i]    = 31'(s3_mag_ff[i]) * 31'(speed_limit_ff);
         div_in_in.rem[i] = limit_prod[i][REM_W-1:0];
         div_in_in.quo[i] = '0;
         div_in_in.neg[i] = s3_wheel_ff[i][WHEEL_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (s4_rdy && s3_valid_ff) begin
         div_in_ff <= div_in_in;
      end
   end

   mwm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid_ff),
      .in_ready  (div_in_ready),
      .in_data   (div_in_ff),
      .out_valid (div_out_valid),
      .out_ready (out_rdy),
      .out_data  (div_out)
   );

   // Output stage: signed quotient when scaled, saturated mix otherwise.
   logic                          rsp_valid_ff, rsp_scaled_ff;
   logic [LANES-1:0][WHEEL_W-1:0] rsp_wheel_ff, rsp_wheel_in;

   always_comb begin
      logic [WHEEL_W-1:0] qs;
      for (int i = 0; i < LANES; i++) begin
         qs = {1'b0, div_out.quo[i]};
         if (!div_out.scaled) begin
            rsp_wheel_in[i] = div_out.wheel[i];
         end else if (div_out.neg[i]) begin
            rsp_wheel_in[i] = ~qs + 16'd1;
         end else begin
            rsp_wheel_in[i] = qs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && div_out_valid) begin
         rsp_wheel_ff  <= rsp_wheel_in;
         rsp_scaled_ff <= div_out.scaled;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_wheel_a = rsp_wheel_ff[0];
   assign rsp_wheel_b = rsp_wheel_ff[1];
   assign rsp_wheel_c = rsp_wheel_ff[2];
   assign rsp_wheel_d = rsp_wheel_ff[3];
   assign rsp_scaled  = rsp_scaled_ff;

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without a held result");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted item missing from stage 1");

endmodule

`default_nettype wire
